### hdl/tdc_pkg.sv
// shared constants and types for the tunnel dispatch classifier
package tdc_pkg;

    localparam int unsigned DEF_MAX_TUNNELS = 8;
    localparam int unsigned DELIVER_W       = 8;
    localparam int unsigned INDEX_W         = 3;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned ADDR_W          = 32;
    localparam int unsigned PORT_W          = 16;
    localparam int unsigned LEN_W           = 12;

    localparam logic [ADDR_W-1:0] MCAST_MASK   = 32'hE000_0000;
    localparam logic [ADDR_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] RIP_GROUP    = 32'hE000_0009;
    localparam logic [ADDR_W-1:0] GATEWAY_ADDR = 32'h2C00_0001;
    localparam logic [PORT_W-1:0] RIP_PORT     = 16'd520;
    localparam logic [LEN_W-1:0]  RIP_MIN_LEN  = 12'd48;
    localparam logic [LEN_W-1:0]  MIN_LEN      = 12'd20;

    // command codes
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // data written into one table entry
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic              mc_in;
        logic              bc_in;
    } t_entry_wr;

    // per-entry match status towards the selector
    typedef struct packed {
        logic              exact;
        logic              pfx_hit;
        logic              fan;
        logic [ADDR_W-1:0] mask;
    } t_lane;

endpackage

### hdl/tdc_req_if.sv
// request channel: table writes and packet headers
interface tdc_req_if;
    import tdc_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  entry_prefix;
    logic [ADDR_W-1:0]  entry_mask;
    logic               entry_multicast_in;
    logic               entry_broadcast_in;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [LEN_W-1:0]   packet_length;

    modport source (
        output valid, command, entry_index, entry_prefix, entry_mask,
               entry_multicast_in, entry_broadcast_in, dest_addr, src_addr,
               src_port, dst_port, packet_length,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_prefix, entry_mask,
               entry_multicast_in, entry_broadcast_in, dest_addr, src_addr,
               src_port, dst_port, packet_length,
        output ready
    );
endinterface

### hdl/tdc_res_if.sv
// result channel: delivery decision per classified packet
interface tdc_res_if;
    import tdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DELIVER_W-1:0] deliver_mask;
    logic                 single_target;
    logic [INDEX_W-1:0]   target_index;
    logic                 routing_update;

    modport source (
        output valid, deliver_mask, single_target, target_index, routing_update,
        input  ready
    );
    modport sink (
        input  valid, deliver_mask, single_target, target_index, routing_update,
        output ready
    );
endinterface

### hdl/tunnel_dispatch_classifier.sv
// top level of the tunnel dispatch classifier
//
// usage
//   i_req carries requests of two kinds: a table write (command 0) stores
//   prefix, mask and accept flags into entry entry_index; a classify
//   (command 1) carries the inner header of a decapsulated packet.
//   o_res gives one result per classify of 20 bytes or more: the tunnel
//   delivery mask, whether one best tunnel was chosen and which, and the
//   routing update flag. writes and short packets give no result.
//   i_cfg_we / i_cfg_wdata set the number of active entries; write it only
//   while the block is idle.
// timing
//   a request passes an input register and then the result register, which
//   drives o_res.valid. one request per cycle is taken when the receiver
//   keeps up; the entry compare and the mask tournament all sit between
//   those two registers.
// reset and stall
//   reset empties both registers and clears the active count; table
//   contents stay undefined until written. when o_res.ready is low the
//   result holds and the input register fills, then i_req.ready drops.
module tunnel_dispatch_classifier #(
    parameter int unsigned MAX_TUNNELS = tdc_pkg::DEF_MAX_TUNNELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tdc_pkg::COUNT_W-1:0]  i_cfg_wdata,
    tdc_req_if.sink                      i_req,
    tdc_res_if.source                    o_res
);
    import tdc_pkg::*;

    // entries beyond the delivery mask width are never used
    localparam int unsigned NUM_ENT = (MAX_TUNNELS < DELIVER_W) ? MAX_TUNNELS : DELIVER_W;

    // configuration
    logic [COUNT_W-1:0] r_count;

    // input register
    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic [INDEX_W-1:0] r_s1_idx;
    t_entry_wr          r_s1_wr;
    logic [ADDR_W-1:0]  r_s1_dest;
    logic [ADDR_W-1:0]  r_s1_src;
    logic [PORT_W-1:0]  r_s1_sport;
    logic [PORT_W-1:0]  r_s1_dport;
    logic [LEN_W-1:0]   r_s1_len;

    // result register
    logic                 r_out_valid;
    logic [DELIVER_W-1:0] r_deliver;
    logic                 r_single;
    logic [INDEX_W-1:0]   r_target;
    logic                 r_rip;

    logic                 produces;
    logic                 out_free;
    logic                 s1_adv;
    logic                 in_take;
    logic                 rip;
    t_lane                lane [NUM_ENT];
    logic [DELIVER_W-1:0] sel_deliver;
    logic                 sel_single;
    logic [INDEX_W-1:0]   sel_target;

    // handshake
    assign produces = (r_s1_cmd == CMD_CLASSIFY) && (r_s1_len >= MIN_LEN);
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_adv   = r_s1_valid && (!produces || out_free);
    assign in_take  = i_req.valid && i_req.ready;

    assign i_req.ready = !r_s1_valid || s1_adv;

    // table writes take effect as the write leaves the input register,
    // so a classify ahead of it still sees the older contents
    genvar g;
    generate
        for (g = 0; g < NUM_ENT; g++) begin : g_ent
            tdc_entry u_entry (
                .i_clk       (i_clk),
                .i_wr_en     (r_s1_valid && (r_s1_cmd == CMD_WRITE)
                              && (r_s1_idx == INDEX_W'(g))),
                .i_wr        (r_s1_wr),
                .i_active    (r_count > COUNT_W'(g)),
                .i_dest_addr (r_s1_dest),
                .o_lane      (lane[g])
            );
        end
    endgenerate

    tdc_select #(
        .NUM_ENT (NUM_ENT)
    ) u_select (
        .i_lane          (lane),
        .o_deliver_mask  (sel_deliver),
        .o_single_target (sel_single),
        .o_target_index  (sel_target)
    );

    // rip update sent by the gateway to the rip group
    assign rip = (r_s1_len > RIP_MIN_LEN) && (r_s1_dest == RIP_GROUP)
              && (r_s1_src == GATEWAY_ADDR) && (r_s1_sport == RIP_PORT)
              && (r_s1_dport == RIP_PORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid && produces;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd       <= i_req.command;
            r_s1_idx       <= i_req.entry_index;
            r_s1_wr.prefix <= i_req.entry_prefix;
            r_s1_wr.mask   <= i_req.entry_mask;
            r_s1_wr.mc_in  <= i_req.entry_multicast_in;
            r_s1_wr.bc_in  <= i_req.entry_broadcast_in;
            r_s1_dest      <= i_req.dest_addr;
            r_s1_src       <= i_req.src_addr;
            r_s1_sport     <= i_req.src_port;
            r_s1_dport     <= i_req.dst_port;
            r_s1_len       <= i_req.packet_length;
        end
        if (out_free && r_s1_valid && produces) begin
            r_deliver <= sel_deliver;
            r_single  <= sel_single;
            r_target  <= sel_target;
            r_rip     <= rip;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.deliver_mask   = r_deliver;
    assign o_res.single_target  = r_single;
    assign o_res.target_index   = r_target;
    assign o_res.routing_update = r_rip;
endmodule

### hdl/tdc_entry.sv
// one tunnel table entry with its address match logic
module tdc_entry (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  tdc_pkg::t_entry_wr        i_wr,
    input  logic                      i_active,
    input  logic [tdc_pkg::ADDR_W-1:0] i_dest_addr,
    output tdc_pkg::t_lane            o_lane
);
    import tdc_pkg::*;

    logic [ADDR_W-1:0] r_prefix;
    logic [ADDR_W-1:0] r_mask;
    logic              r_mc_in;
    logic              r_bc_in;
    logic [ADDR_W-1:0] net;
    logic              mc_hit;
    logic              bc_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prefix <= i_wr.prefix;
            r_mask   <= i_wr.mask;
            r_mc_in  <= i_wr.mc_in;
            r_bc_in  <= i_wr.bc_in;
        end
    end

    assign net    = r_prefix & r_mask;
    assign mc_hit = r_mc_in && ((i_dest_addr & MCAST_MASK) == MCAST_MASK);
    // network, directed and all-ones broadcast
    assign bc_hit = r_bc_in && ((net == i_dest_addr) || ((r_prefix | ~r_mask) == i_dest_addr)
                                || (i_dest_addr == ALL_ONES));

    assign o_lane.exact   = i_active && (r_prefix == i_dest_addr);
    assign o_lane.pfx_hit = i_active && (net == (i_dest_addr & r_mask));
    assign o_lane.fan     = i_active && (mc_hit || bc_hit);
    assign o_lane.mask    = r_mask;
endmodule

### hdl/tdc_select.sv
// best tunnel tournament and fan-out mask
module tdc_select #(
    parameter int unsigned NUM_ENT = tdc_pkg::DEF_MAX_TUNNELS
) (
    input  tdc_pkg::t_lane                 i_lane [NUM_ENT],
    output logic [tdc_pkg::DELIVER_W-1:0]  o_deliver_mask,
    output logic                           o_single_target,
    output logic [tdc_pkg::INDEX_W-1:0]    o_target_index
);
    import tdc_pkg::*;

    localparam int unsigned LEVELS = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 0;
    localparam int unsigned LEAVES = 1 << LEVELS;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W:0]    key;
        logic [INDEX_W-1:0] idx;
    } t_cand;

    // left holds the lower indexes, so it wins ties
    function automatic t_cand pick(input t_cand lo, input t_cand hi);
        t_cand res;
        if (hi.valid && (!lo.valid || (hi.key > lo.key))) begin
            res = hi;
        end else begin
            res = lo;
        end
        return res;
    endfunction

    t_cand             node [2*LEAVES];
    logic [NUM_ENT-1:0] fan;

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < NUM_ENT) begin : g_used
                // exact hit outranks any mask, first exact hit wins
                assign node[LEAVES+g].valid = i_lane[g].exact
                    || (i_lane[g].pfx_hit && (i_lane[g].mask != '0));
                assign node[LEAVES+g].key   = i_lane[g].exact ? {1'b1, ALL_ONES}
                                                             : {1'b0, i_lane[g].mask};
                assign node[LEAVES+g].idx   = INDEX_W'(g);
                assign fan[g]               = i_lane[g].fan;
            end else begin : g_pad
                assign node[LEAVES+g] = '0;
            end
        end
        for (g = 1; g < LEAVES; g++) begin : g_node
            assign node[g] = pick(node[2*g], node[2*g+1]);
        end
    endgenerate

    assign node[0] = '0;

    always_comb begin
        o_single_target = node[1].valid;
        o_target_index  = node[1].valid ? node[1].idx : '0;
        o_deliver_mask  = '0;
        for (int i = 0; i < NUM_ENT; i++) begin
            o_deliver_mask[i] = node[1].valid ? (node[1].idx == INDEX_W'(i)) : fan[i];
        end
    end
endmodule
